>>> src/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants for the BMP byte-stream pixel extractor.
// ----------------------------------------------------------------------------
package bmp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL       = 2'd0;
  localparam logic [1:0] KIND_HDR_OK      = 2'd1;
  localparam logic [1:0] KIND_MALFORMED   = 2'd2;
  localparam logic [1:0] KIND_UNSUPPORTED = 2'd3;

  // Magic bytes and header layout
  localparam logic [7:0]  MAGIC_B      = 8'h42;
  localparam logic [7:0]  MAGIC_M      = 8'h4D;
  localparam logic [4:0]  POS_OFF_LO   = 5'd10;
  localparam logic [4:0]  POS_OFF_HI   = 5'd13;
  localparam logic [4:0]  POS_WID_LO   = 5'd18;
  localparam logic [4:0]  POS_WID_HI   = 5'd21;
  localparam logic [4:0]  POS_HGT_LO   = 5'd22;
  localparam logic [4:0]  POS_HGT_HI   = 5'd25;
  localparam logic [4:0]  POS_BPP_LO   = 5'd28;
  localparam logic [4:0]  POS_HDR_END  = 5'd29;
  localparam logic [31:0] MIN_OFFSET   = 32'd30;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_SKIP   = 5'b00100,
    PH_PIXELS = 5'b01000,
    PH_PAD    = 5'b10000
  } phase_t;

  // Input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] pixel_color;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [5:0]  bits_per_pixel;
    logic        last_pixel;
  } out_beat_t;

endpackage

>>> src/bmp_stream_pixel_extractor.sv
// ----------------------------------------------------------------------------
// bmp_stream_pixel_extractor
// Parses a BMP file one byte per beat: header fields, data skip, pixels
// with coordinates (bottom-up rows) and row padding.
// ----------------------------------------------------------------------------
// A result is registered on the clock edge that accepts its input byte.
// Throughput: 1 byte per cycle; the single output register is refilled in
//   the cycle it is drained, so in_ready only drops while a result stalls.
// Reset: synchronous active-low rst_n idles the parser and empties the
//   output register; a beat with file_start restarts parsing at any time.
// ----------------------------------------------------------------------------
module bmp_stream_pixel_extractor #(
  parameter int MAX_DIM = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmp_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bmp_pkg::out_beat_t out_data
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  // State registers
  bmp_pkg::phase_t    phase_r, phase_nxt;
  logic [31:0]        pos_r, pos_nxt;
  logic [31:0]        off_r, off_nxt;
  logic [31:0]        wid_r, wid_nxt;
  logic [31:0]        hgt_r, hgt_nxt;
  logic [15:0]        bpp_r, bpp_nxt;
  logic [2:0]         nb_r, nb_nxt;
  logic [DIM_W-1:0]   col_r, col_nxt;
  logic [DIM_W-1:0]   row_r, row_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [31:0]        color_r, color_nxt;
  logic [1:0]         pad_r, pad_nxt;
  logic               out_valid_r, emit_nxt;
  bmp_pkg::out_beat_t out_data_r, out_nxt;

  logic               accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Per-byte parse step
  always_comb begin
    bmp_pkg::phase_t   ph;
    logic [7:0]        b;
    logic [4:0]        pos5;
    logic [31:0]       color_full;
    logic [DIM_W:0]    col_inc;
    logic [4:0]        prod;
    logic [1:0]        pad_calc;
    logic              bpp_ok;
    logic              dim_ok;

    b          = in_data.data_byte;
    ph         = phase_r;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    off_nxt    = off_r;
    wid_nxt    = wid_r;
    hgt_nxt    = hgt_r;
    bpp_nxt    = bpp_r;
    nb_nxt     = nb_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    idx_nxt    = idx_r;
    color_nxt  = color_r;
    pad_nxt    = pad_r;
    emit_nxt   = 1'b0;
    out_nxt    = '0;

    // file_start wipes the old file and parses this byte as byte 0
    if (in_data.file_start) begin
      ph        = bmp_pkg::PH_HEADER;
      phase_nxt = bmp_pkg::PH_HEADER;
      pos_nxt   = '0;
      off_nxt   = '0;
      wid_nxt   = '0;
      hgt_nxt   = '0;
      bpp_nxt   = '0;
      col_nxt   = '0;
      row_nxt   = '0;
      idx_nxt   = '0;
      color_nxt = '0;
      pad_nxt   = '0;
    end

    pos5       = pos_nxt[4:0];
    color_full = color_r | (32'(b) << {idx_r, 3'b000});
    col_inc    = (DIM_W + 1)'(col_r) + (DIM_W + 1)'(1);
    prod       = 5'(wid_r[1:0]) * 5'(nb_r);
    pad_calc   = 2'(2'd0 - prod[1:0]);
    bpp_ok     = 1'b0;
    dim_ok     = 1'b0;

    case (ph)
      bmp_pkg::PH_HEADER: begin
        // collect little-endian header fields
        if (pos5 >= bmp_pkg::POS_OFF_LO && pos5 <= bmp_pkg::POS_OFF_HI)
          off_nxt[{2'(pos5 - bmp_pkg::POS_OFF_LO), 3'b000} +: 8] = b;
        if (pos5 >= bmp_pkg::POS_WID_LO && pos5 <= bmp_pkg::POS_WID_HI)
          wid_nxt[{2'(pos5 - bmp_pkg::POS_WID_LO), 3'b000} +: 8] = b;
        if (pos5 >= bmp_pkg::POS_HGT_LO && pos5 <= bmp_pkg::POS_HGT_HI)
          hgt_nxt[{2'(pos5 - bmp_pkg::POS_HGT_LO), 3'b000} +: 8] = b;
        if (pos5 >= bmp_pkg::POS_BPP_LO && pos5 <= bmp_pkg::POS_HDR_END)
          bpp_nxt[{pos5[0], 3'b000} +: 8] = b;
        pos_nxt = pos_nxt + 32'd1;

        bpp_ok = (bpp_nxt == 16'd8) || (bpp_nxt == 16'd16) ||
                 (bpp_nxt == 16'd24) || (bpp_nxt == 16'd32);
        dim_ok = (wid_nxt != '0) && (wid_nxt <= 32'(MAX_DIM)) &&
                 (hgt_nxt != '0) && (hgt_nxt <= 32'(MAX_DIM));

        if ((pos5 == 5'd0 && b != bmp_pkg::MAGIC_B) ||
            (pos5 == 5'd1 && b != bmp_pkg::MAGIC_M)) begin
          phase_nxt           = bmp_pkg::PH_IDLE;
          emit_nxt            = 1'b1;
          out_nxt.result_kind = bmp_pkg::KIND_MALFORMED;
        end else if (pos5 == bmp_pkg::POS_HDR_END) begin
          emit_nxt = 1'b1;
          if (off_nxt < bmp_pkg::MIN_OFFSET) begin
            phase_nxt           = bmp_pkg::PH_IDLE;
            out_nxt.result_kind = bmp_pkg::KIND_MALFORMED;
          end else if (!bpp_ok || !dim_ok) begin
            phase_nxt           = bmp_pkg::PH_IDLE;
            out_nxt.result_kind = bmp_pkg::KIND_UNSUPPORTED;
          end else begin
            col_nxt   = '0;
            row_nxt   = DIM_W'(hgt_nxt - 32'd1);
            idx_nxt   = '0;
            color_nxt = '0;
            nb_nxt    = bpp_nxt[5:3];
            phase_nxt = (off_nxt == bmp_pkg::MIN_OFFSET) ? bmp_pkg::PH_PIXELS
                                                          : bmp_pkg::PH_SKIP;
            out_nxt.result_kind    = bmp_pkg::KIND_HDR_OK;
            out_nxt.image_width    = wid_nxt[12:0];
            out_nxt.image_height   = hgt_nxt[12:0];
            out_nxt.bits_per_pixel = bpp_nxt[5:0];
          end
        end
      end

      bmp_pkg::PH_SKIP: begin
        // advance to the pixel data offset
        pos_nxt = pos_r + 32'd1;
        if (pos_nxt == off_r)
          phase_nxt = bmp_pkg::PH_PIXELS;
      end

      bmp_pkg::PH_PIXELS: begin
        if (3'({1'b0, idx_r}) + 3'd1 < nb_r) begin
          idx_nxt   = idx_r + 2'd1;
          color_nxt = color_full;
        end else begin
          emit_nxt            = 1'b1;
          out_nxt.result_kind = bmp_pkg::KIND_PIXEL;
          out_nxt.pixel_x     = 12'(col_r);
          out_nxt.pixel_y     = 12'(row_r);
          out_nxt.pixel_color = color_full;
          idx_nxt             = '0;
          color_nxt           = '0;
          if (32'(col_inc) >= wid_r) begin
            // end of row
            col_nxt = '0;
            if (row_r == '0) begin
              out_nxt.last_pixel = 1'b1;
              phase_nxt          = bmp_pkg::PH_IDLE;
            end else begin
              row_nxt = row_r - DIM_W'(1);
              pad_nxt = pad_calc;
              if (pad_calc != 2'd0)
                phase_nxt = bmp_pkg::PH_PAD;
            end
          end else begin
            col_nxt = DIM_W'(col_inc);
          end
        end
      end

      bmp_pkg::PH_PAD: begin
        // drop row padding bytes
        pad_nxt = pad_r - 2'd1;
        if (pad_nxt == 2'd0)
          phase_nxt = bmp_pkg::PH_PIXELS;
      end

      default: begin
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bmp_pkg::PH_IDLE;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r   <= pos_nxt;
      off_r   <= off_nxt;
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      bpp_r   <= bpp_nxt;
      nb_r    <= nb_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      idx_r   <= idx_nxt;
      color_r <= color_nxt;
      pad_r   <= pad_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= emit_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit_nxt) begin
      out_data_r <= out_nxt;
    end
  end

  // Assertions
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("in_ready low with empty output register");

  a_last_is_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last_pixel |->
      out_data_r.result_kind == bmp_pkg::KIND_PIXEL && out_data_r.pixel_y == 12'd0)
    else $error("last pixel flagged off the top row");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && emit_nxt && out_nxt.last_pixel |=> phase_r == bmp_pkg::PH_IDLE)
    else $error("parser not idle after last pixel");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bmp_pkg::PH_PIXELS |-> 32'(col_r) < wid_r)
    else $error("column counter beyond image width");

endmodule
